// File: hdl/ecc_pkg.sv
// shared constants, command codes and item plan type of the elevator car controller
package ecc_pkg;

	localparam int FLOOR_COUNT = 16;

	localparam logic [7:0] CAR_LETTER_RST = 8'd101;
	localparam logic [7:0] FLOOR_BASE     = 8'h61;
	localparam logic [7:0] NO_FLOOR       = 8'd32;

	localparam logic [7:0] CH_LAMP_ON  = 8'h4C;
	localparam logic [7:0] CH_LAMP_OFF = 8'h44;
	localparam logic [7:0] CH_UP       = 8'h73;
	localparam logic [7:0] CH_DOWN     = 8'h64;
	localparam logic [7:0] CH_STOP     = 8'h70;
	localparam logic [7:0] CH_OPEN     = 8'h61;
	localparam logic [7:0] CH_CLOSE    = 8'h66;
	localparam logic [7:0] CH_INT      = 8'h49;
	localparam logic [7:0] CH_EXT      = 8'h45;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;

	localparam int CMD_COUNT = 7;

	typedef enum logic [2:0] {
		CMD_LAMP_ON  = 3'd0,
		CMD_MOVE     = 3'd1,
		CMD_STOP     = 3'd2,
		CMD_OPEN     = 3'd3,
		CMD_CLOSE    = 3'd4,
		CMD_LAMP_OFF = 3'd5,
		CMD_LAMP_RPT = 3'd6
	} cmd_t;

	typedef struct packed {
		logic [CMD_COUNT-1:0] mask;
		logic [7:0]           lamp_floor;
		logic                 go_down;
		logic [7:0]           target;
	} plan_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic [3:0] digit_val(input logic [7:0] c);
		logic [7:0] d;
		d = c - CH_ZERO;
		return d[3:0];
	endfunction

	// two-digit value, 0..99
	function automatic logic [6:0] two_digit(input logic [7:0] hi, input logic [7:0] lo);
		return 7'({3'b000, digit_val(hi)} * 7'd10) + {3'b000, digit_val(lo)};
	endfunction

endpackage

// File: hdl/ecc_if.sv
// item channels of the elevator car controller: request in, command byte out, car letter write
interface ecc_req_if;
	logic       valid;
	logic       ready;
	logic [7:0] first_char;
	logic [7:0] second_char;
	logic [7:0] third_char;
	modport source (output valid, output first_char, output second_char, output third_char,
		input ready);
	modport sink (input valid, input first_char, input second_char, input third_char,
		output ready);
endinterface

interface ecc_cmd_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_byte;
	modport source (output valid, output out_byte, output last_byte, input ready);
	modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface

interface ecc_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] car_letter;
	modport source (output valid, output car_letter, input ready);
	modport sink (input valid, input car_letter, output ready);
endinterface

// File: hdl/elevator_car_controller.sv
// elevator car controller top level: request decode, car state and command byte stream
//
// channel  dir  payload                                    accepted when
// req      in   first_char, second_char, third_char        req.valid && req.ready
// cmd      out  out_byte, last_byte                        cmd.valid && cmd.ready
// cfg      in   car_letter                                 cfg.valid && cfg.ready
//
// a request item updates the car state in the cycle it is accepted; its commands
// go to a one-item plan slot and move to the serializer once it is idle or sends
// the final byte of the plan before; an item sends 0 to 24 bytes at one byte
// per cycle while cmd.ready is high, and one item can wait in the slot meanwhile
// reset clears car state, plan slot and serializer; car letter returns to 'e'
// a stalled cmd channel holds the byte; req is taken while the plan slot is free or emptying
module elevator_car_controller (
	input  logic      clk,
	input  logic      arst_n,
	ecc_req_if.sink   req,
	ecc_cmd_if.source cmd,
	ecc_cfg_if.sink   cfg
);

	logic [7:0]     car_letter_q;
	logic           take_ready;
	logic           accept;
	logic           plan_v;
	ecc_pkg::plan_t plan;

	assign cfg.ready = 1'b1;
	assign req.ready = take_ready;
	assign accept = req.valid && take_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			car_letter_q <= ecc_pkg::CAR_LETTER_RST;
		end else if (cfg.valid && cfg.ready) begin
			car_letter_q <= cfg.car_letter;
		end
	end

	ecc_step u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.first_char  (req.first_char),
		.second_char (req.second_char),
		.third_char  (req.third_char),
		.plan_v      (plan_v),
		.plan        (plan)
	);

	ecc_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.plan_v     (plan_v),
		.plan       (plan),
		.car_letter (car_letter_q),
		.take_ready (take_ready),
		.cmd        (cmd)
	);

	// an idle serializer never blocks a new item
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.valid |-> req.ready)
		else $error("request blocked while command stream idle");

	// the final byte of every item is a carriage return
	a_last_cr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.last_byte |-> cmd.out_byte == ecc_pkg::CH_CR)
		else $error("final byte is not a carriage return");

	// the stream only pauses after the final byte of an item
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(cmd.valid) |-> $past(cmd.last_byte) && $past(cmd.ready))
		else $error("command stream stopped inside an item");

endmodule

// File: hdl/ecc_step.sv
// car state registers and per-item decode into a command plan
module ecc_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           first_char,
	input  logic [7:0]           second_char,
	input  logic [7:0]           third_char,
	output logic                 plan_v,
	output ecc_pkg::plan_t       plan
);

	logic [7:0] cur_floor_q;
	logic [7:0] tgt_floor_q;
	logic       held_q;
	logic       moving_q;

	logic       c1_dig;
	logic       c2_dig;
	logic       c3_dig;
	logic [6:0] rep_val;
	logic       rep_ok;
	logic [6:0] ext_val;
	logic [7:0] ext_letter;
	logic [7:0] cur_n;
	logic [7:0] tgt_n;
	logic       held_mid;
	logic       do_move;
	logic       arrive;

	always_comb begin
		c1_dig = ecc_pkg::is_digit(first_char);
		c2_dig = ecc_pkg::is_digit(second_char);
		c3_dig = ecc_pkg::is_digit(third_char);
		rep_val = c2_dig ? ecc_pkg::two_digit(first_char, second_char)
			: {3'b000, ecc_pkg::digit_val(first_char)};
		rep_ok = c1_dig && (rep_val < 7'(ecc_pkg::FLOOR_COUNT));
		cur_n = rep_ok ? (ecc_pkg::FLOOR_BASE + {1'b0, rep_val}) : cur_floor_q;

		ext_val = ecc_pkg::two_digit(second_char, third_char);
		ext_letter = (c2_dig && c3_dig && (ext_val < 7'(ecc_pkg::FLOOR_COUNT)))
			? (ecc_pkg::FLOOR_BASE + {1'b0, ext_val}) : ecc_pkg::NO_FLOOR;

		tgt_n = tgt_floor_q;
		held_mid = held_q;
		if (first_char == ecc_pkg::CH_INT) begin
			tgt_n = second_char;
			held_mid = 1'b1;
		end else if (first_char == ecc_pkg::CH_EXT) begin
			tgt_n = ext_letter;
			held_mid = 1'b1;
		end

		do_move = !moving_q && (tgt_n != cur_n);
		arrive = held_mid && (tgt_n == cur_n);

		plan = '0;
		plan.mask[ecc_pkg::CMD_LAMP_ON]  = (first_char == ecc_pkg::CH_INT);
		plan.mask[ecc_pkg::CMD_MOVE]     = do_move;
		plan.mask[ecc_pkg::CMD_STOP]     = arrive;
		plan.mask[ecc_pkg::CMD_OPEN]     = arrive;
		plan.mask[ecc_pkg::CMD_CLOSE]    = arrive;
		plan.mask[ecc_pkg::CMD_LAMP_OFF] = arrive;
		plan.mask[ecc_pkg::CMD_LAMP_RPT] = arrive;
		plan.lamp_floor = second_char;
		plan.go_down = tgt_n < cur_n;
		plan.target = tgt_n;
		plan_v = accept && (|plan.mask);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_floor_q <= ecc_pkg::FLOOR_BASE;
			tgt_floor_q <= ecc_pkg::FLOOR_BASE;
			held_q <= 1'b0;
			moving_q <= 1'b0;
		end else if (accept) begin
			cur_floor_q <= cur_n;
			tgt_floor_q <= tgt_n;
			held_q <= held_mid && !arrive;
			moving_q <= arrive ? 1'b0 : (moving_q || do_move);
		end
	end

endmodule

// File: hdl/ecc_emit.sv
// one-slot plan buffer and byte serializer for the car command stream
module ecc_emit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            plan_v,
	input  ecc_pkg::plan_t  plan,
	input  logic [7:0]      car_letter,
	output logic            take_ready,
	ecc_cmd_if.source       cmd
);

	ecc_pkg::plan_t pend_q;
	logic           pend_v_q;
	ecc_pkg::plan_t act_q;
	logic [1:0]     idx_q;

	logic                          fire;
	logic                          end_cmd;
	logic [ecc_pkg::CMD_COUNT-1:0] mask_rest;
	logic                          drain_done;
	logic                          pend_load;
	ecc_pkg::cmd_t                 cur_cmd;
	logic [7:0]                    op_byte;
	logic [7:0]                    arg_byte;

	always_comb begin
		cur_cmd = ecc_pkg::CMD_LAMP_ON;
		for (int i = ecc_pkg::CMD_COUNT - 1; i >= 0; i--) begin
			if (act_q.mask[i]) cur_cmd = ecc_pkg::cmd_t'(3'(i));
		end
	end

	always_comb begin
		unique case (cur_cmd)
			ecc_pkg::CMD_LAMP_ON:  op_byte = ecc_pkg::CH_LAMP_ON;
			ecc_pkg::CMD_MOVE:     op_byte = act_q.go_down ? ecc_pkg::CH_DOWN : ecc_pkg::CH_UP;
			ecc_pkg::CMD_STOP:     op_byte = ecc_pkg::CH_STOP;
			ecc_pkg::CMD_OPEN:     op_byte = ecc_pkg::CH_OPEN;
			ecc_pkg::CMD_CLOSE:    op_byte = ecc_pkg::CH_CLOSE;
			ecc_pkg::CMD_LAMP_OFF: op_byte = ecc_pkg::CH_LAMP_OFF;
			ecc_pkg::CMD_LAMP_RPT: op_byte = ecc_pkg::CH_LAMP_OFF;
			default:               op_byte = ecc_pkg::CH_STOP;
		endcase
		case (cur_cmd) inside
			ecc_pkg::CMD_LAMP_ON:                         arg_byte = act_q.lamp_floor;
			ecc_pkg::CMD_LAMP_OFF, ecc_pkg::CMD_LAMP_RPT: arg_byte = act_q.target;
			default:                                      arg_byte = ecc_pkg::CH_LF;
		endcase
		unique case (idx_q)
			2'd0:    cmd.out_byte = car_letter;
			2'd1:    cmd.out_byte = op_byte;
			2'd2:    cmd.out_byte = arg_byte;
			default: cmd.out_byte = ecc_pkg::CH_CR;
		endcase
	end

	always_comb begin
		cmd.valid = |act_q.mask;
		mask_rest = act_q.mask & (act_q.mask - 1'b1);
		cmd.last_byte = (idx_q == 2'd3) && (mask_rest == '0);
		fire = cmd.valid && cmd.ready;
		end_cmd = fire && (idx_q == 2'd3);
		drain_done = !cmd.valid || (end_cmd && (mask_rest == '0));
		pend_load = pend_v_q && drain_done;
		take_ready = !pend_v_q || pend_load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			act_q <= '0;
			idx_q <= 2'd0;
		end else begin
			if (plan_v) pend_v_q <= 1'b1;
			else if (pend_load) pend_v_q <= 1'b0;
			if (pend_load) begin
				act_q <= pend_q;
				idx_q <= 2'd0;
			end else if (end_cmd) begin
				act_q.mask <= mask_rest;
				idx_q <= 2'd0;
			end else if (fire) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (plan_v) pend_q <= plan;
	end

endmodule
